// File: hw/rtl/lbf_pkg.sv
package lbf_pkg;

  localparam int DEFAULT_TABLE_DEPTH   = 256;
  localparam int PCT_MAX               = 100;
  localparam int FRAC_BITS             = 8;
  localparam int LEVEL_COUNT_RESET     = 255;
  localparam int DEFAULT_PERCENT_RESET = 100;
  localparam int LAST_LEVEL_RESET      = DEFAULT_PERCENT_RESET * LEVEL_COUNT_RESET / PCT_MAX;
  localparam int DIV_N_W               = 18;
  localparam int DIV_D_W               = 16;
  localparam int CFG_IDX_W             = 2;
  localparam logic [17:0] ELAPSED_MAX  = 18'h3FFFF;

  // x / 100 equals (x * 5243) >> 19 for every x below 43690, which covers
  // any percent times any level count.
  localparam int PCT_RECIP             = 5243;
  localparam int PCT_RECIP_SHIFT       = 19;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_FADE_PCT  = 3'd1,
    MODE_FADE_LAST = 3'd2,
    MODE_TBL_WRITE = 3'd3,
    MODE_DIRECT    = 3'd4
  } lbf_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_COUNT     = 2'd0,
    REG_DEFAULT_PERCENT = 2'd1
  } lbf_reg_t;

  typedef enum logic [2:0] {
    DIV_INC,
    DIV_DELAY,
    DIV_STEP,
    DIV_REQPCT,
    DIV_LASTPCT
  } lbf_div_op_t;

  typedef enum logic {
    RD_LEVEL,
    RD_REQUEST
  } lbf_rd_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LAST_S,
    S_DISPATCH,
    S_FADE,
    S_FADE_RD,
    S_INC_W,
    S_DLY_S,
    S_DLY_W,
    S_TICK1,
    S_STEP_W,
    S_TICK2,
    S_END_RD,
    S_MULW,
    S_RPCT_S,
    S_RPCT_W,
    S_LPCT_S,
    S_LPCT_W,
    S_OUT
  } lbf_state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        enable;
    logic [6:0]  percent;
    logic [15:0] steps_count;
    logic [15:0] duration_ms;
    logic [15:0] start_delay_ms;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [7:0]  duty_value;
  } lbf_in_item_t;

  typedef struct packed {
    logic       duty_written;
    logic [7:0] duty;
    logic       is_fading;
    logic       is_active;
    logic [6:0] requested_percent;
    logic [6:0] last_percent;
  } lbf_out_item_t;

  typedef struct packed {
    logic        load_item;
    logic        div_start;
    lbf_div_op_t div_op;
    logic        last_reload;
    logic        last_from_req;
    logic        lvl_from_pct;
    logic        lvl_from_last;
    logic        tbl_write;
    logic        duty_direct;
    logic        elapsed_inc;
    logic        mem_rd;
    lbf_rd_sel_t rd_sel;
    logic        set_req;
    logic        fade_clear;
    logic        fade_setup1;
    logic        fade_setup2;
    logic        mul_load;
    logic        duty_step;
    logic        duty_end;
    logic        out_load;
  } lbf_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       enable;
    logic       fade_active;
    logic       elapsed_le_delay;
    logic       step_ge_total;
    logic       step_ne_prev;
    logic       pct_zero;
    logic       req_nonzero;
    logic       lvl_eq_req;
    logic       target_eq_duty;
    logic       last_dirty;
    logic       div_done;
    logic       tidx_ok;
  } lbf_status_t;

endpackage

// File: hw/rtl/lbf_ifs.sv
interface lbf_req_if;
  logic                 valid;
  logic                 ready;
  lbf_pkg::lbf_in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lbf_rsp_if;
  logic                  valid;
  logic                  ready;
  lbf_pkg::lbf_out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/led_brightness_fader_top.sv
// LED brightness fader.
// Requests arrive on the req channel (valid/ready); each accepted request
// gives exactly one result on the rsp channel, held in an output register
// until the receiver takes it. Mode selects a tick, a fade to a percent,
// a fade to the last brightness, a gamma table write or a direct duty.
// The block works on one request at a time. Divisions by a variable go
// through one shared radix-2 divider of 18 iterations; divisions by 100
// use a reciprocal multiplication. A register write marks the last level
// for reloading, which the next request does in state S_LAST_S at no extra
// cost. The next request is taken once the result has been accepted, so a
// stalled receiver holds off new requests without losing anything.
// Configuration writes use cfg_we, cfg_index and cfg_wdata; the user must
// make them only while idle; the block itself does not enforce this.
// Reset clears the fade state and restores the register defaults; the gamma
// table keeps no reset value and must be loaded before any fade reads it.
module led_brightness_fader_top #(
  parameter int TABLE_DEPTH = lbf_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  lbf_req_if.sink                       req,
  lbf_rsp_if.source                     rsp
);
  lbf_pkg::lbf_cmd_t    cmd;
  lbf_pkg::lbf_status_t status;

  lbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lbf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_in   (req.data),
    .cmd       (cmd),
    .status    (status),
    .result    (rsp.data)
  );
endmodule

// File: hw/rtl/lbf_div.sv
module lbf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lbf_pkg::DIV_N_W-1:0] dividend,
  input  logic [lbf_pkg::DIV_D_W-1:0] divisor,
  output logic [lbf_pkg::DIV_N_W-1:0] quotient,
  output logic                        done
);
  localparam int NW = lbf_pkg::DIV_N_W;
  localparam int DW = lbf_pkg::DIV_D_W;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] trial;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem, quotient[NW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[DW+1]) begin
        rem      <= trial[DW-1:0];
        quotient <= {quotient[NW-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DW-1:0];
        quotient <= {quotient[NW-2:0], 1'b0};
      end
    end
  end
endmodule

// File: hw/rtl/lbf_dp.sv
module lbf_dp #(
  parameter int TABLE_DEPTH = lbf_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_wdata,
  input  lbf_pkg::lbf_in_item_t           item_in,
  input  lbf_pkg::lbf_cmd_t               cmd,
  output lbf_pkg::lbf_status_t            status,
  output lbf_pkg::lbf_out_item_t          result
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = lbf_pkg::DIV_N_W;
  localparam int DW = lbf_pkg::DIV_D_W;

  lbf_pkg::lbf_in_item_t item;
  lbf_pkg::lbf_div_op_t  op;

  logic [7:0]         level_count;
  logic [6:0]         default_percent;
  logic               last_dirty;
  logic [7:0]         last_level;
  logic [7:0]         requested_level;
  logic [7:0]         current_duty;
  logic [7:0]         start_duty;
  logic signed [16:0] step_increment;
  logic [15:0]        total_steps;
  logic [15:0]        previous_step;
  logic [15:0]        step_delay;
  logic [17:0]        elapsed_ticks;
  logic               fade_active;
  logic [15:0]        start_delay;
  logic [7:0]         lvl;
  logic [17:0]        step_q;
  logic signed [33:0] product;
  logic               diff_neg;
  logic               written;
  logic [6:0]         req_pct;
  logic [6:0]         last_pct;

  logic [7:0] mem [TABLE_DEPTH];
  logic [7:0] mem_q;

  logic [7:0]     lev_eff;
  logic [6:0]     pct_sat;
  logic [6:0]     dpct_sat;
  logic [15:0]    steps_eff;
  logic [7:0]     diff_mag;
  logic [14:0]    last_prod;
  logic [14:0]    lvl_prod;
  logic [26:0]    last_scaled;
  logic [26:0]    lvl_scaled;
  logic [7:0]     last_calc;
  logic [7:0]     lvl_calc;
  logic [NW-1:0]  div_n;
  logic [DW-1:0]  div_d;
  logic [NW-1:0]  div_q;
  logic           div_done;
  logic [AW-1:0]  rd_addr;
  logic signed [33:0] v;

  function automatic logic [AW-1:0] clamp_addr(input logic [7:0] x);
    if ({1'b0, x} >= 9'(TABLE_DEPTH)) return AW'(TABLE_DEPTH - 1);
    return x[AW-1:0];
  endfunction

  function automatic logic [6:0] sat_pct(input logic [NW-1:0] q);
    if (q > NW'(lbf_pkg::PCT_MAX)) return 7'(lbf_pkg::PCT_MAX);
    return q[6:0];
  endfunction

  assign lev_eff   = (level_count == 8'd0) ? 8'd1 : level_count;
  assign pct_sat   = (item.percent > 7'(lbf_pkg::PCT_MAX)) ? 7'(lbf_pkg::PCT_MAX) : item.percent;
  assign dpct_sat  = (default_percent > 7'(lbf_pkg::PCT_MAX)) ? 7'(lbf_pkg::PCT_MAX)
                                                                : default_percent;
  assign steps_eff = (item.steps_count == 16'd0) ? 16'd1 : item.steps_count;
  assign diff_mag  = (mem_q > current_duty) ? mem_q - current_duty : current_duty - mem_q;

  // Percent to level: the division by 100 is a multiplication by its reciprocal.
  assign last_prod   = 15'(dpct_sat) * 15'(lev_eff);
  assign lvl_prod    = 15'(pct_sat) * 15'(lev_eff);
  assign last_scaled = 27'(last_prod) * 27'(lbf_pkg::PCT_RECIP);
  assign lvl_scaled  = 27'(lvl_prod) * 27'(lbf_pkg::PCT_RECIP);
  assign last_calc   = last_scaled[lbf_pkg::PCT_RECIP_SHIFT +: 8];
  assign lvl_calc    = lvl_scaled[lbf_pkg::PCT_RECIP_SHIFT +: 8];

  always_comb begin
    div_n = '0;
    div_d = DW'(lbf_pkg::PCT_MAX);
    case (cmd.div_op)
      lbf_pkg::DIV_INC: begin
        div_n = NW'({diff_mag, 8'h00});
        div_d = steps_eff;
      end
      lbf_pkg::DIV_DELAY: begin
        div_n = NW'(item.duration_ms);
        div_d = steps_eff;
      end
      lbf_pkg::DIV_STEP: begin
        div_n = elapsed_ticks - {2'b00, start_delay};
        div_d = step_delay;
      end
      lbf_pkg::DIV_REQPCT: begin
        div_n = NW'(15'(requested_level) * 15'(lbf_pkg::PCT_MAX));
        div_d = DW'(lev_eff);
      end
      lbf_pkg::DIV_LASTPCT: begin
        div_n = NW'(15'(last_level) * 15'(lbf_pkg::PCT_MAX));
        div_d = DW'(lev_eff);
      end
      default: div_n = '0;
    endcase
  end

  lbf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  assign rd_addr = (cmd.rd_sel == lbf_pkg::RD_REQUEST) ? clamp_addr(requested_level)
                                                       : clamp_addr(lvl);

  always_ff @(posedge clk) begin
    if (cmd.tbl_write) mem[item.table_index[AW-1:0]] <= item.table_value;
    if (cmd.mem_rd) mem_q <= mem[rd_addr];
  end

  assign v = 34'(signed'({18'd0, start_duty, 8'h00})) + product;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count     <= 8'(lbf_pkg::LEVEL_COUNT_RESET);
      default_percent <= 7'(lbf_pkg::DEFAULT_PERCENT_RESET);
      last_dirty      <= 1'b0;
      last_level      <= 8'(lbf_pkg::LAST_LEVEL_RESET);
      requested_level <= '0;
      current_duty    <= '0;
      start_duty      <= '0;
      step_increment  <= '0;
      total_steps     <= '0;
      previous_step   <= '0;
      step_delay      <= 16'd1;
      elapsed_ticks   <= '0;
      fade_active     <= 1'b0;
      start_delay     <= '0;
      written         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lbf_pkg::REG_LEVEL_COUNT) begin
          level_count <= cfg_wdata;
          last_dirty  <= 1'b1;
        end else if (cfg_index == lbf_pkg::REG_DEFAULT_PERCENT) begin
          default_percent <= cfg_wdata[6:0];
          last_dirty      <= 1'b1;
        end
      end
      if (cmd.load_item) written <= 1'b0;
      if (cmd.last_reload) begin
        last_level <= last_calc;
        last_dirty <= 1'b0;
      end
      if (div_done) begin
        case (op)
          lbf_pkg::DIV_INC:
            step_increment <= diff_neg ? -signed'(div_q[16:0]) : signed'(div_q[16:0]);
          lbf_pkg::DIV_DELAY:
            step_delay <= (div_q == '0) ? 16'd1 : div_q[15:0];
          default: ;
        endcase
      end
      if (cmd.last_from_req) last_level <= requested_level;
      if (cmd.set_req) requested_level <= lvl;
      if (cmd.fade_clear) fade_active <= 1'b0;
      if (cmd.fade_setup1) begin
        total_steps <= steps_eff;
        start_duty  <= current_duty;
      end
      if (cmd.fade_setup2) begin
        previous_step <= '0;
        fade_active   <= 1'b1;
        start_delay   <= item.start_delay_ms;
        elapsed_ticks <= '0;
      end
      if (cmd.elapsed_inc && elapsed_ticks != lbf_pkg::ELAPSED_MAX)
        elapsed_ticks <= elapsed_ticks + 18'd1;
      if (cmd.duty_direct) begin
        current_duty <= item.duty_value;
        written      <= 1'b1;
      end
      if (cmd.duty_step) begin
        // A negative sum clamps to zero before the fraction is dropped.
        current_duty  <= v[33] ? 8'd0 : v[15:8];
        previous_step <= step_q[15:0];
        written       <= 1'b1;
      end
      if (cmd.duty_end) begin
        current_duty <= mem_q;
        fade_active  <= 1'b0;
        written      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= item_in;
    if (cmd.div_start) op <= cmd.div_op;
    if (cmd.lvl_from_pct) lvl <= lvl_calc;
    if (cmd.lvl_from_last) lvl <= last_level;
    if (cmd.fade_setup1) diff_neg <= (mem_q < current_duty);
    if (cmd.mul_load) product <= signed'({1'b0, step_q[15:0]}) * step_increment;
    if (div_done) begin
      case (op)
        lbf_pkg::DIV_STEP:    step_q   <= div_q;
        lbf_pkg::DIV_REQPCT:  req_pct  <= sat_pct(div_q);
        lbf_pkg::DIV_LASTPCT: last_pct <= sat_pct(div_q);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      result.duty_written      <= written;
      result.duty              <= current_duty;
      result.is_fading         <= fade_active;
      result.is_active         <= (requested_level != 8'd0) || fade_active;
      result.requested_percent <= req_pct;
      result.last_percent      <= last_pct;
    end
  end

  assign status.mode             = item.mode;
  assign status.enable           = item.enable;
  assign status.fade_active      = fade_active;
  assign status.elapsed_le_delay = elapsed_ticks <= {2'b00, start_delay};
  assign status.step_ge_total    = step_q >= {2'b00, total_steps};
  assign status.step_ne_prev     = step_q[15:0] != previous_step;
  assign status.pct_zero         = item.percent == 7'd0;
  assign status.req_nonzero      = requested_level != 8'd0;
  assign status.lvl_eq_req       = lvl == requested_level;
  assign status.target_eq_duty   = mem_q == current_duty;
  assign status.last_dirty       = last_dirty;
  assign status.div_done         = div_done;
  assign status.tidx_ok          = {1'b0, item.table_index} < 9'(TABLE_DEPTH);
endmodule

// File: hw/rtl/lbf_ctrl.sv
module lbf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lbf_pkg::lbf_status_t status,
  output lbf_pkg::lbf_cmd_t    cmd
);
  lbf_pkg::lbf_state_t state, state_next;

  assign req_ready = (state == lbf_pkg::S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lbf_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lbf_pkg::S_IDLE:
        if (req_valid && req_ready) state_next = lbf_pkg::S_LAST_S;
      lbf_pkg::S_LAST_S:
        state_next = lbf_pkg::S_DISPATCH;
      lbf_pkg::S_DISPATCH: begin
        case (status.mode)
          lbf_pkg::MODE_TICK:
            state_next = (status.fade_active && status.enable) ? lbf_pkg::S_TICK1
                                                              : lbf_pkg::S_RPCT_S;
          lbf_pkg::MODE_FADE_PCT:
            state_next = lbf_pkg::S_FADE;
          lbf_pkg::MODE_FADE_LAST:
            state_next = (!status.req_nonzero && !status.fade_active) ? lbf_pkg::S_FADE
                                                                      : lbf_pkg::S_RPCT_S;
          default:
            state_next = lbf_pkg::S_RPCT_S;
        endcase
      end
      lbf_pkg::S_FADE:
        state_next = status.lvl_eq_req ? lbf_pkg::S_RPCT_S : lbf_pkg::S_FADE_RD;
      lbf_pkg::S_FADE_RD:
        state_next = status.target_eq_duty ? lbf_pkg::S_RPCT_S : lbf_pkg::S_INC_W;
      lbf_pkg::S_INC_W:
        if (status.div_done) state_next = lbf_pkg::S_DLY_S;
      lbf_pkg::S_DLY_S:
        state_next = lbf_pkg::S_DLY_W;
      lbf_pkg::S_DLY_W:
        if (status.div_done) state_next = lbf_pkg::S_RPCT_S;
      lbf_pkg::S_TICK1:
        state_next = status.elapsed_le_delay ? lbf_pkg::S_RPCT_S : lbf_pkg::S_STEP_W;
      lbf_pkg::S_STEP_W:
        if (status.div_done) state_next = lbf_pkg::S_TICK2;
      lbf_pkg::S_TICK2: begin
        if (status.step_ge_total) state_next = lbf_pkg::S_END_RD;
        else if (status.step_ne_prev) state_next = lbf_pkg::S_MULW;
        else state_next = lbf_pkg::S_RPCT_S;
      end
      lbf_pkg::S_END_RD: state_next = lbf_pkg::S_RPCT_S;
      lbf_pkg::S_MULW:   state_next = lbf_pkg::S_RPCT_S;
      lbf_pkg::S_RPCT_S: state_next = lbf_pkg::S_RPCT_W;
      lbf_pkg::S_RPCT_W:
        if (status.div_done) state_next = lbf_pkg::S_LPCT_S;
      lbf_pkg::S_LPCT_S: state_next = lbf_pkg::S_LPCT_W;
      lbf_pkg::S_LPCT_W:
        if (status.div_done) state_next = lbf_pkg::S_OUT;
      lbf_pkg::S_OUT:    state_next = lbf_pkg::S_IDLE;
      default:           state_next = lbf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_op = lbf_pkg::DIV_REQPCT;
    cmd.rd_sel = lbf_pkg::RD_LEVEL;
    case (state)
      lbf_pkg::S_IDLE:
        cmd.load_item = req_valid && req_ready;
      lbf_pkg::S_LAST_S:
        cmd.last_reload = status.last_dirty;
      lbf_pkg::S_DISPATCH: begin
        case (status.mode)
          lbf_pkg::MODE_TICK:
            cmd.elapsed_inc = status.fade_active && status.enable;
          lbf_pkg::MODE_FADE_PCT: begin
            cmd.lvl_from_pct  = 1'b1;
            cmd.last_from_req = status.pct_zero && status.req_nonzero;
          end
          lbf_pkg::MODE_FADE_LAST:
            cmd.lvl_from_last = !status.req_nonzero && !status.fade_active;
          lbf_pkg::MODE_TBL_WRITE:
            cmd.tbl_write = status.tidx_ok;
          lbf_pkg::MODE_DIRECT:
            cmd.duty_direct = 1'b1;
          default: ;
        endcase
      end
      lbf_pkg::S_FADE: begin
        cmd.set_req = !status.lvl_eq_req;
        cmd.mem_rd  = !status.lvl_eq_req;
        cmd.rd_sel  = lbf_pkg::RD_LEVEL;
      end
      lbf_pkg::S_FADE_RD: begin
        cmd.fade_clear  = status.target_eq_duty;
        cmd.fade_setup1 = !status.target_eq_duty;
        cmd.div_start   = !status.target_eq_duty;
        cmd.div_op      = lbf_pkg::DIV_INC;
      end
      lbf_pkg::S_DLY_S: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = lbf_pkg::DIV_DELAY;
      end
      lbf_pkg::S_DLY_W:
        cmd.fade_setup2 = status.div_done;
      lbf_pkg::S_TICK1: begin
        cmd.div_start = !status.elapsed_le_delay;
        cmd.div_op    = lbf_pkg::DIV_STEP;
      end
      lbf_pkg::S_TICK2: begin
        cmd.mem_rd   = status.step_ge_total;
        cmd.rd_sel   = lbf_pkg::RD_REQUEST;
        cmd.mul_load = !status.step_ge_total && status.step_ne_prev;
      end
      lbf_pkg::S_END_RD: cmd.duty_end  = 1'b1;
      lbf_pkg::S_MULW:   cmd.duty_step = 1'b1;
      lbf_pkg::S_RPCT_S: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = lbf_pkg::DIV_REQPCT;
      end
      lbf_pkg::S_LPCT_S: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = lbf_pkg::DIV_LASTPCT;
      end
      lbf_pkg::S_OUT: cmd.out_load = 1'b1;
      default: ;
    endcase
  end

  // A new request is never taken while a result is still on offer.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !out_valid)
    else $error("request taken while result pending");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result register not marked valid");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != lbf_pkg::S_IDLE))
    else $error("accepted request left controller idle");

  a_start_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("division finished without any iterations");
endmodule

// File: sim/tb_led_brightness_fader_top.sv
module tb_led_brightness_fader_top;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lbf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  lbf_req_if req_ch();
  lbf_rsp_if rsp_ch();

  led_brightness_fader_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  // Predictor state of the fader.
  logic [7:0]  lvl_count;
  logic [6:0]  dflt_pct;
  logic [7:0]  gamma [0:255];
  logic [7:0]  req_level;
  logic [7:0]  last_level;
  logic [7:0]  cur_duty;
  logic [7:0]  start_duty;
  int          step_inc;
  int unsigned total_steps;
  int unsigned prev_step;
  int unsigned step_delay;
  int unsigned elapsed;
  bit          fading;
  int unsigned start_delay;

  lbf_pkg::lbf_in_item_t  pending_reqs[$];
  lbf_pkg::lbf_out_item_t expected_rsps[$];
  int  n_errors;
  int  hold_off;
  bit  stim_done;
  int  burst_left;
  int  gap_left;

  function automatic int unsigned eff_levels();
    return (lvl_count == 0) ? 1 : lvl_count;
  endfunction

  function automatic logic [7:0] level_of(int unsigned pct);
    if (pct > 100) pct = 100;
    return 8'((pct * eff_levels()) / 100);
  endfunction

  function automatic logic [6:0] pct_of(int unsigned lvl);
    int unsigned p;
    p = lvl * 100 / eff_levels();
    return (p > 100) ? 7'd100 : 7'(p);
  endfunction

  task automatic begin_fade(logic [7:0] lvl, int unsigned steps, int unsigned dur,
                            int unsigned dly);
    logic [7:0] target;
    if (lvl == req_level) return;
    req_level = lvl;
    target = gamma[lvl];
    if (target == cur_duty) begin
      fading = 0;
      return;
    end
    if (steps == 0) steps = 1;
    total_steps = steps;
    start_duty = cur_duty;
    step_inc = ((int'(target) - int'(cur_duty)) * 256) / int'(steps);
    prev_step = 0;
    fading = 1;
    step_delay = dur / steps;
    if (step_delay == 0) step_delay = 1;
    start_delay = dly;
    elapsed = 0;
  endtask

  task automatic predict_fader(input lbf_pkg::lbf_in_item_t it);
    lbf_pkg::lbf_out_item_t r;
    int unsigned step;
    longint v;
    r = '0;
    case (it.mode)
      lbf_pkg::MODE_TICK: begin
        if (fading && it.enable) begin
          if (elapsed < 262143) elapsed++;
          if (elapsed > start_delay) begin
            step = (elapsed - start_delay) / step_delay;
            if (step >= total_steps) begin
              fading = 0;
              cur_duty = gamma[req_level];
              r.duty_written = 1;
            end else if (step != prev_step) begin
              v = longint'(start_duty) * 256 + longint'(step) * longint'(step_inc);
              if (v < 0) v = 0;
              cur_duty = 8'(v / 256);
              prev_step = step;
              r.duty_written = 1;
            end
          end
        end
      end
      lbf_pkg::MODE_FADE_PCT: begin
        if (it.percent == 0 && req_level != 0) last_level = req_level;
        begin_fade(level_of(it.percent), it.steps_count, it.duration_ms, it.start_delay_ms);
      end
      lbf_pkg::MODE_FADE_LAST: begin
        if (req_level == 0 && !fading)
          begin_fade(last_level, it.steps_count, it.duration_ms, it.start_delay_ms);
      end
      lbf_pkg::MODE_TBL_WRITE: begin
        gamma[it.table_index] = it.table_value;
      end
      lbf_pkg::MODE_DIRECT: begin
        cur_duty = it.duty_value;
        r.duty_written = 1;
      end
      default: ;
    endcase
    r.duty = cur_duty;
    r.is_fading = fading;
    r.is_active = (req_level != 0) || fading;
    r.requested_percent = pct_of(req_level);
    r.last_percent = pct_of(last_level);
    expected_rsps.push_back(r);
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  // Driver: bursts of requests with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_fader(req_ch.data);
        void'(pending_reqs.pop_front());
      end
      if (req_ch.valid && !req_ch.ready) begin
        // Hold the offered request.
      end else if (gap_left > 0) begin
        req_ch.valid <= 0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        req_ch.valid <= 1;
        req_ch.data <= pending_reqs[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 0;
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk) begin
    lbf_pkg::lbf_out_item_t e;
    if (rst) begin
      rsp_ch.ready <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result %p", rsp_ch.data);
          n_errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (e.duty_written !== rsp_ch.data.duty_written) begin
            $error("duty_written exp %0d got %0d", e.duty_written, rsp_ch.data.duty_written);
            n_errors++;
          end
          if (e.duty !== rsp_ch.data.duty) begin
            $error("duty exp %0d got %0d", e.duty, rsp_ch.data.duty);
            n_errors++;
          end
          if (e.is_fading !== rsp_ch.data.is_fading) begin
            $error("is_fading exp %0d got %0d", e.is_fading, rsp_ch.data.is_fading);
            n_errors++;
          end
          if (e.is_active !== rsp_ch.data.is_active) begin
            $error("is_active exp %0d got %0d", e.is_active, rsp_ch.data.is_active);
            n_errors++;
          end
          if (e.requested_percent !== rsp_ch.data.requested_percent) begin
            $error("requested_percent exp %0d got %0d", e.requested_percent,
                   rsp_ch.data.requested_percent);
            n_errors++;
          end
          if (e.last_percent !== rsp_ch.data.last_percent) begin
            $error("last_percent exp %0d got %0d", e.last_percent, rsp_ch.data.last_percent);
            n_errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp_ch.ready <= 0;
      end else if (!stim_done && $urandom_range(0, 999) == 0) begin
        hold_off <= $urandom_range(300, 800);
        rsp_ch.ready <= 0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 15) < 11) || ($urandom_range(0, 7) == 0);
      end
    end
  end

  function automatic lbf_pkg::lbf_in_item_t make_item(lbf_pkg::lbf_mode_t m);
    lbf_pkg::lbf_in_item_t it;
    it = '0;
    it.mode = m;
    it.enable = 1;
    return it;
  endfunction

  function automatic lbf_pkg::lbf_in_item_t rand_noise();
    lbf_pkg::lbf_in_item_t it;
    it.mode = 3'($urandom_range(0, 7));
    it.enable = 1'($urandom);
    it.percent = 7'($urandom);
    it.steps_count = 16'($urandom);
    it.duration_ms = 16'($urandom);
    it.start_delay_ms = 16'($urandom);
    it.table_index = 8'($urandom);
    it.table_value = 8'($urandom);
    it.duty_value = 8'($urandom);
    return it;
  endfunction

  task automatic push_fade(lbf_pkg::lbf_mode_t m, int unsigned pct);
    lbf_pkg::lbf_in_item_t it;
    it = rand_noise();
    it.mode = m;
    it.percent = 7'(pct);
    if ($urandom_range(0, 9) == 0) begin
      it.steps_count = 16'($urandom);
      it.duration_ms = 16'($urandom);
      it.start_delay_ms = 16'($urandom);
    end else begin
      it.steps_count = 16'($urandom_range(0, 12));
      it.duration_ms = 16'($urandom_range(0, 40));
      it.start_delay_ms = 16'($urandom_range(0, 6));
    end
    pending_reqs.push_back(it);
  endtask

  task automatic write_reg(lbf_pkg::lbf_reg_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == lbf_pkg::REG_LEVEL_COUNT) lvl_count = val;
    else dflt_pct = val[6:0];
    last_level = level_of(dflt_pct);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req_ch.valid);
    wait (expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    lbf_pkg::lbf_in_item_t it;
    int n;
    rst = 1;
    cfg_we = 0;
    cfg_index = lbf_pkg::REG_LEVEL_COUNT;
    cfg_wdata = 0;
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
    n_errors = 0;
    hold_off = 0;
    stim_done = 0;
    lvl_count = 255;
    dflt_pct = 100;
    req_level = 0;
    last_level = level_of(100);
    cur_duty = 0;
    start_duty = 0;
    step_inc = 0;
    total_steps = 0;
    prev_step = 0;
    step_delay = 1;
    elapsed = 0;
    fading = 0;
    start_delay = 0;
    for (int i = 0; i < 256; i++) begin
      gamma[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: load the whole table first so that no fade reads a blank entry.
    for (int i = 0; i < 256; i++) begin
      it = make_item(lbf_pkg::MODE_TBL_WRITE);
      it.table_index = 8'(i);
      it.table_value = (i == 255) ? 8'hFF : 8'(i * 7 / 8);
      pending_reqs.push_back(it);
    end
    it = make_item(lbf_pkg::MODE_DIRECT); it.duty_value = 8'hFF; pending_reqs.push_back(it);
    it = make_item(lbf_pkg::MODE_DIRECT); it.duty_value = 8'h00; pending_reqs.push_back(it);
    // Percent above 100 with zero steps and zero delay, then a long fade to 50 percent.
    it = make_item(lbf_pkg::MODE_FADE_PCT); it.percent = 7'd127; pending_reqs.push_back(it);
    it = make_item(lbf_pkg::MODE_TICK); pending_reqs.push_back(it);
    it = make_item(lbf_pkg::MODE_FADE_PCT); it.percent = 7'd50; it.steps_count = 16'hFFFF;
    it.duration_ms = 16'hFFFF; it.start_delay_ms = 16'd2; pending_reqs.push_back(it);
    for (int i = 0; i < 4; i++) begin
      it = make_item(lbf_pkg::MODE_TICK); it.enable = i[0]; pending_reqs.push_back(it);
    end
    // Direct duty while fading, unknown modes, then back to zero.
    it = make_item(lbf_pkg::MODE_DIRECT); it.duty_value = 8'h55; pending_reqs.push_back(it);
    it = make_item(lbf_pkg::lbf_mode_t'(3'd5)); pending_reqs.push_back(it);
    it = make_item(lbf_pkg::lbf_mode_t'(3'd7)); pending_reqs.push_back(it);
    it = make_item(lbf_pkg::MODE_FADE_PCT); it.percent = 7'd0; it.steps_count = 16'd3;
    it.duration_ms = 16'd6; pending_reqs.push_back(it);
    for (int i = 0; i < 8; i++) pending_reqs.push_back(make_item(lbf_pkg::MODE_TICK));
    it = make_item(lbf_pkg::MODE_FADE_LAST); it.steps_count = 16'd2; pending_reqs.push_back(it);
    for (int i = 0; i < 4; i++) pending_reqs.push_back(make_item(lbf_pkg::MODE_TICK));
    drain();

    // Random phases under several register settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(lbf_pkg::REG_LEVEL_COUNT, 8'd1);
          write_reg(lbf_pkg::REG_DEFAULT_PERCENT, 8'd0);
        end
        1: begin
          write_reg(lbf_pkg::REG_LEVEL_COUNT, 8'd0);
          write_reg(lbf_pkg::REG_DEFAULT_PERCENT, 8'd127);
        end
        2: begin
          write_reg(lbf_pkg::REG_LEVEL_COUNT, 8'd100);
          write_reg(lbf_pkg::REG_DEFAULT_PERCENT, 8'd37);
        end
        3: begin
          write_reg(lbf_pkg::REG_LEVEL_COUNT, 8'($urandom_range(1, 255)));
          write_reg(lbf_pkg::REG_DEFAULT_PERCENT, 8'($urandom_range(0, 100)));
        end
        default: begin
          write_reg(lbf_pkg::REG_LEVEL_COUNT, 8'd255);
          write_reg(lbf_pkg::REG_DEFAULT_PERCENT, 8'd100);
        end
      endcase
      n = 0;
      while (n < 200) begin
        case ($urandom_range(0, 9))
          0, 1: push_fade(lbf_pkg::MODE_FADE_PCT, $urandom_range(0, 127));
          2: push_fade(lbf_pkg::MODE_FADE_LAST, 0);
          3: begin
            it = rand_noise();
            if (it.mode == lbf_pkg::MODE_FADE_PCT || it.mode == lbf_pkg::MODE_FADE_LAST)
              it.mode = lbf_pkg::MODE_TICK;
            pending_reqs.push_back(it);
          end
          default: begin
            for (int k = $urandom_range(1, 30); k > 0; k--) begin
              it = rand_noise();
              it.mode = lbf_pkg::MODE_TICK;
              it.enable = ($urandom_range(0, 7) != 0);
              pending_reqs.push_back(it);
              n++;
            end
          end
        endcase
        n++;
      end
      drain();
    end
    stim_done = 1;
    drain();
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/lbf_pkg.sv
hw/rtl/lbf_ifs.sv
hw/rtl/lbf_div.sv
hw/rtl/lbf_dp.sv
hw/rtl/lbf_ctrl.sv
hw/rtl/led_brightness_fader_top.sv
sim/tb_led_brightness_fader_top.sv
